### hw/rtl/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg: shared types and constants of the paged stack allocator
// Page geometry, field widths, request/response payloads, header layout.
// ----------------------------------------------------------------------------
package psa_pkg;

   localparam int PAGE_BYTES   = 1024;
   localparam int PAGES        = 8;
   localparam int HEADER_BYTES = 16;

   localparam int PAGE_LOG2   = $clog2(PAGE_BYTES);
   localparam int STORE_DEPTH = PAGES * PAGE_BYTES;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   // Fixed field widths
   localparam int MODE_W = 3;
   localparam int ADDR_W = 14;
   localparam int SIZE_W = 14;
   localparam int ALOG_W = 4;
   localparam int OFS_W  = 13;
   localparam int PAGE_W = 3;
   localparam int CNT_W  = 4;

   // Wide enough for address + header + offset + alignment mask
   localparam int WIDE_W = 18;

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC  = 3'd0,
      MODE_FREE   = 3'd1,
      MODE_RESET  = 3'd2,
      MODE_MARK   = 3'd3,
      MODE_REWIND = 3'd4
   } mode_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [SIZE_W-1:0] size;
      logic [ALOG_W-1:0] align_log2;
      logic [OFS_W-1:0]  offset;
      logic [ADDR_W-1:0] pointer;
      logic [PAGE_W-1:0] page_index;
      logic              dead_mark;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] result_address;
      logic [PAGE_W-1:0] result_page;
      logic              result_dead;
      logic              failed;
      logic              order_error;
      logic [SIZE_W-1:0] freed_size;
   } rsp_type;

   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic [ADDR_W-1:0] prev;
   } hdr_type;

   localparam int HDR_W = $bits(hdr_type);

endpackage

### hw/rtl/psa_ram.sv
// ----------------------------------------------------------------------------
// psa_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; no reset on contents.
// ----------------------------------------------------------------------------
module psa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/paged_stack_allocator.sv
// Sequence: a request is accepted in idle and registered, and its response is
// registered when work commits; free reads its header on acceptance, and
// allocate tries each page from the current one until one fits or none is left.
// Throughput: one request at a time; a response not yet taken stalls the
// commit of the next request. Synchronous reset clears address, page and
// exhausted flag and sets the page count to PAGES; the header RAM is kept.
// ----------------------------------------------------------------------------
// paged_stack_allocator: LIFO bump allocator over consecutive pages
// Keeps the bump pointer, current page and exhausted flag in registers and
// the per-block headers (size, previous address) in a RAM.
// ----------------------------------------------------------------------------
module paged_stack_allocator (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  psa_pkg::req_type         req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output psa_pkg::rsp_type         rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [psa_pkg::CNT_W-1:0] csr_data
);

   typedef enum logic {
      ST_IDLE,
      ST_WORK
   } state_type;

   localparam int WW = psa_pkg::WIDE_W;
   localparam int AW = psa_pkg::ADDR_W;
   localparam int PW = psa_pkg::PAGE_W;
   localparam int CW = psa_pkg::CNT_W;

   state_type                   state_ff, state_in;
   logic [AW-1:0]               cur_addr_ff, cur_addr_in;
   logic [PW-1:0]               cur_page_ff, cur_page_in;
   logic                        dead_ff, dead_in;
   logic [CW-1:0]               pages_ff, pages_in;
   psa_pkg::req_type            req_ff, req_in;
   logic [AW-1:0]               try_addr_ff, try_addr_in;
   logic [PW-1:0]               try_page_ff, try_page_in;
   logic [WW-1:0]               k1_ff, k1_in;
   logic [WW-1:0]               k2_ff, k2_in;
   logic [WW-1:0]               mask_ff, mask_in;
   logic [psa_pkg::SIZE_W-1:0]  need_ff, need_in;
   logic                        bad_ff, bad_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   psa_pkg::rsp_type            rsp_ff, rsp_in;

   logic                        accept;
   logic                        out_free;
   logic                        commit;
   logic [CW-1:0]               avail;
   logic [WW-1:0]               c_pt, cm_pt, a_pt, end1, a_sum, p_wide;
   logic [CW-1:0]               next_page;
   logic                        fit, last, done;
   logic                        beyond;
   psa_pkg::hdr_type            hdr_rd, hdr_wr;
   logic [psa_pkg::SIZE_W-1:0]  hdr_size;
   logic [AW-1:0]               hdr_prev;
   logic [AW-psa_pkg::PAGE_LOG2-1:0] prev_page_wide;
   logic [PW-1:0]               prev_page;
   logic [psa_pkg::HDR_W-1:0]   ram_rd_data;
   logic                        ram_wr_en, ram_rd_en;
   logic [psa_pkg::STORE_AW-1:0] ram_wr_addr;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Page count register: zero acts as one, large values as PAGES
   always_comb begin
      avail = pages_ff;
      if (pages_ff == '0) begin
         avail = CW'(1);
      end else if (pages_ff > CW'(psa_pkg::PAGES)) begin
         avail = CW'(psa_pkg::PAGES);
      end
   end

   // Fit test for the page under trial
   assign c_pt      = WW'(try_addr_ff) + k1_ff;
   assign cm_pt     = WW'(try_addr_ff) + k2_ff;
   assign a_pt      = cm_pt & ~mask_ff;
   assign next_page = CW'(try_page_ff) + CW'(1);
   assign end1      = WW'(next_page) << psa_pkg::PAGE_LOG2;
   assign a_sum     = a_pt + WW'(need_ff);
   assign fit       = (c_pt < end1) && (a_sum <= end1);
   assign last      = next_page >= avail;
   assign p_wide    = a_pt - WW'(req_ff.offset);

   // Header read back for free
   assign hdr_rd   = psa_pkg::hdr_type'(ram_rd_data);
   assign beyond   = req_ff.pointer[AW-1];
   assign hdr_size = beyond ? '0 : hdr_rd.size;
   assign hdr_prev = beyond ? '0 : hdr_rd.prev;
   assign prev_page_wide = hdr_prev[AW-1:psa_pkg::PAGE_LOG2];
   assign prev_page = (prev_page_wide > (AW-psa_pkg::PAGE_LOG2)'(psa_pkg::PAGES - 1))
                      ? PW'(psa_pkg::PAGES - 1) : PW'(prev_page_wide);

   assign done   = (req_ff.mode != psa_pkg::MODE_ALLOC) || bad_ff || fit || last;
   assign commit = (state_ff == ST_WORK) && done && out_free;

   assign ram_rd_en   = accept && (req_data.mode == psa_pkg::MODE_FREE);
   assign ram_wr_en   = commit && (req_ff.mode == psa_pkg::MODE_ALLOC) && !bad_ff && fit;
   assign ram_wr_addr = p_wide[psa_pkg::STORE_AW-1:0];
   assign hdr_wr.size = req_ff.size;
   assign hdr_wr.prev = cur_addr_ff;

   always_comb begin
      state_in     = state_ff;
      cur_addr_in  = cur_addr_ff;
      cur_page_in  = cur_page_ff;
      dead_in      = dead_ff;
      pages_in     = pages_ff;
      req_in       = req_ff;
      try_addr_in  = try_addr_ff;
      try_page_in  = try_page_ff;
      k1_in        = k1_ff;
      k2_in        = k2_ff;
      mask_in      = mask_ff;
      need_in      = need_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      if (csr_valid && csr_ready) begin
         pages_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in      = req_data;
               try_addr_in = cur_addr_ff;
               try_page_in = cur_page_ff;
               mask_in     = (WW'(1) << req_data.align_log2) - WW'(1);
               k1_in       = WW'(psa_pkg::HEADER_BYTES) + WW'(req_data.offset);
               k2_in       = WW'(psa_pkg::HEADER_BYTES) + WW'(req_data.offset)
                             + ((WW'(1) << req_data.align_log2) - WW'(1));
               need_in     = req_data.size - psa_pkg::SIZE_W'(req_data.offset);
               bad_in      = dead_ff || (req_data.size == '0)
                             || (psa_pkg::SIZE_W'(req_data.offset) >= req_data.size);
               state_in    = ST_WORK;
            end
         end
         ST_WORK: begin
            if (!done) begin
               // advance to the start of the next page
               try_page_in = PW'(next_page);
               try_addr_in = AW'(WW'(next_page) << psa_pkg::PAGE_LOG2);
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               state_in     = ST_IDLE;
               case (req_ff.mode)
                  psa_pkg::MODE_ALLOC: begin
                     if (bad_ff) begin
                        rsp_in.failed = 1'b1;
                     end else if (fit) begin
                        rsp_in.result_address = AW'(p_wide);
                        cur_addr_in           = AW'(a_sum);
                        cur_page_in           = try_page_ff;
                     end else begin
                        rsp_in.failed = 1'b1;
                        dead_in       = 1'b1;
                        cur_addr_in   = '0;
                        cur_page_in   = '0;
                     end
                  end
                  psa_pkg::MODE_FREE: begin
                     rsp_in.freed_size  = hdr_size;
                     rsp_in.order_error = dead_ff
                        || ((AW+1)'(req_ff.pointer) + (AW+1)'(hdr_size)
                            != (AW+1)'(cur_addr_ff));
                     cur_addr_in = hdr_prev;
                     cur_page_in = prev_page;
                     dead_in     = 1'b0;
                  end
                  psa_pkg::MODE_RESET: begin
                     cur_addr_in = '0;
                     cur_page_in = '0;
                     dead_in     = 1'b0;
                  end
                  psa_pkg::MODE_MARK: begin
                     rsp_in.result_address = cur_addr_ff;
                     rsp_in.result_page    = cur_page_ff;
                     rsp_in.result_dead    = dead_ff;
                  end
                  psa_pkg::MODE_REWIND: begin
                     cur_addr_in = req_ff.pointer;
                     cur_page_in = (req_ff.page_index > PW'(psa_pkg::PAGES - 1))
                                   ? PW'(psa_pkg::PAGES - 1) : req_ff.page_index;
                     dead_in     = req_ff.dead_mark;
                  end
                  default: begin
                     rsp_in = '0;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_addr_ff  <= '0;
         cur_page_ff  <= '0;
         dead_ff      <= 1'b0;
         pages_ff     <= CW'(psa_pkg::PAGES);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_addr_ff  <= cur_addr_in;
         cur_page_ff  <= cur_page_in;
         dead_ff      <= dead_in;
         pages_ff     <= pages_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      try_addr_ff <= try_addr_in;
      try_page_ff <= try_page_in;
      k1_ff       <= k1_in;
      k2_ff       <= k2_in;
      mask_ff     <= mask_in;
      need_ff     <= need_in;
      bad_ff      <= bad_in;
      rsp_ff      <= rsp_in;
   end

   psa_ram #(
      .WIDTH(psa_pkg::HDR_W),
      .DEPTH(psa_pkg::STORE_DEPTH)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (hdr_wr),
      .rd_en   (ram_rd_en),
      .rd_addr (req_data.pointer[psa_pkg::STORE_AW-1:0]),
      .rd_data (ram_rd_data)
   );

   a_accept_work: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_WORK))
      else $error("accepted request did not enter work state");

   a_wr_alloc_only: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_WORK) && (req_ff.mode == psa_pkg::MODE_ALLOC))
      else $error("header write outside an allocate commit");

   a_commit_slot: assert property (@(posedge clock) disable iff (reset)
      commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before transfer");

   a_rd_free_only: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |-> (state_ff == ST_IDLE) && !ram_wr_en)
      else $error("header read collides with work state");

   a_fit_in_page: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> (cur_addr_ff <= AW'(psa_pkg::STORE_DEPTH)))
      else $error("allocation left the page area");

endmodule
